@@ rtl/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants, operation codes and the command and status bundles that
// join the sorted timer queue controller to its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

  localparam int NumTimers  = 16;
  localparam int IdW        = $clog2(NumTimers);
  localparam int CntW       = $clog2(NumTimers + 1);
  localparam int TimeW      = 64;
  localparam int MaxResults = 16;
  localparam int ResW       = $clog2(MaxResults + 1);

  localparam logic [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};

  // Operation codes of a request. Code 3 is unused and answers a plain reply.
  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_DISARM = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef logic [IdW-1:0]          slot_t;
  typedef logic signed [TimeW-1:0] time_t;

  typedef struct packed {
    logic in_ready;
    logic pos_clr;
    logic pos_inc;
    logic use_head;
    logic remove;
    logic insert;
    logic pop;
    logic out_load;
    logic out_fired;
    logic out_status;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] op;
    logic       id_armed;
    logic       slot_match;
    logic       wake_lt_time;
    logic       time_lt_wake;
    logic       at_end;
    logic       empty;
    logic       pop_limit;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/stq_if.sv @@
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if
// Valid/ready channels that carry timer requests in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface stq_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [3:0]           timer_id;
  logic signed [63:0]   time_value;

  modport source (output valid, operation, timer_id, time_value, input ready);
  modport sink   (input valid, operation, timer_id, time_value, output ready);
endinterface

interface stq_out_if;
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic                 fired;
  logic [3:0]           fired_id;
  logic signed [63:0]   fired_wake_time;
  logic signed [63:0]   head_wake_time;
  logic                 new_earliest;
  logic                 last;

  modport source (output valid, status, fired, fired_id, fired_wake_time,
                  head_wake_time, new_earliest, last, input ready);
  modport sink   (input valid, status, fired, fired_id, fired_wake_time,
                  head_wake_time, new_earliest, last, output ready);
endinterface

`default_nettype wire

@@ rtl/stq_datapath.sv @@
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted slot list, per-slot wake times and armed flags, the walk position,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  stq_pkg::dp_cmd_t       cmd,
  output stq_pkg::dp_stat_t      stat,
  stq_in_if.sink                 in_req,
  stq_out_if.source              out_res
);
  import stq_pkg::*;

  logic [1:0]          op_q;
  slot_t               id_q;
  time_t               time_q;
  logic [CntW-1:0]     pos;
  logic [ResW-1:0]     pop_n;
  logic [CntW-1:0]     count;
  slot_t               order [NumTimers];
  time_t               wake  [NumTimers];
  logic [NumTimers-1:0] armed;
  logic                early;
  slot_t               fired_id_q;
  time_t               fired_wake_q;

  logic                out_valid;
  logic                in_fire;
  slot_t               rd_idx;
  slot_t               rd_slot;
  time_t               rd_wake;
  time_t               head_time;

  assign in_req.ready = cmd.in_ready;
  assign in_fire      = in_req.valid && cmd.in_ready;

  // One read port into the list; the head is read at position zero.
  assign rd_idx    = cmd.use_head ? '0 : pos[IdW-1:0];
  assign rd_slot   = order[rd_idx];
  assign rd_wake   = wake[rd_slot];
  assign head_time = (count == '0) ? time_t'(TimeMax) : rd_wake;

  assign stat.in_fire      = in_fire;
  assign stat.op           = op_q;
  assign stat.id_armed     = armed[id_q];
  assign stat.slot_match   = (rd_slot == id_q);
  assign stat.wake_lt_time = (rd_wake < time_q);
  assign stat.time_lt_wake = (time_q < rd_wake);
  assign stat.at_end       = (pos == count);
  assign stat.empty        = (count == '0);
  assign stat.pop_limit    = (pop_n == ResW'(MaxResults));
  assign stat.out_free     = !out_valid || out_res.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= in_req.operation;
      id_q   <= in_req.timer_id;
      time_q <= in_req.time_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      pop_n <= '0;
      count <= '0;
      armed <= '0;
      early <= 1'b0;
    end else begin
      if (in_fire || cmd.pos_clr) begin
        pos <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + CntW'(1);
      end
      if (in_fire) begin
        pop_n <= '0;
        early <= 1'b0;
      end
      if (cmd.remove || cmd.pop) begin
        count          <= count - CntW'(1);
        armed[rd_slot] <= 1'b0;
      end else if (cmd.insert) begin
        count       <= count + CntW'(1);
        armed[id_q] <= 1'b1;
        early       <= (pos == '0);
      end
      if (cmd.pop) begin
        pop_n <= pop_n + ResW'(1);
      end
    end
  end

  // List shifts: a removal closes the gap at the read position, an insert
  // opens one there.
  always_ff @(posedge clk) begin
    if (cmd.remove || cmd.pop) begin
      for (int i = 0; i < NumTimers - 1; i++) begin
        if (IdW'(i) >= rd_idx) begin
          order[i] <= order[i+1];
        end
      end
    end else if (cmd.insert) begin
      for (int i = 1; i < NumTimers; i++) begin
        if (IdW'(i) > rd_idx) begin
          order[i] <= order[i-1];
        end
      end
      order[rd_idx] <= id_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      wake[id_q] <= time_q;
    end
    if (cmd.pop) begin
      fired_id_q   <= rd_slot;
      fired_wake_q <= rd_wake;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res.status          <= cmd.out_status;
      out_res.fired           <= cmd.out_fired;
      out_res.fired_id        <= cmd.out_fired ? fired_id_q : '0;
      out_res.fired_wake_time <= cmd.out_fired ? fired_wake_q : '0;
      out_res.head_wake_time  <= head_time;
      out_res.new_earliest    <= cmd.out_fired ? 1'b0 : early;
      out_res.last            <= cmd.out_last;
    end
  end

  assign out_res.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for arm, disarm and tick: walks the sorted list one position per
// cycle and steps the datapath through removal, insertion and expiry.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  stq_pkg::dp_stat_t  stat,
  output stq_pkg::dp_cmd_t   cmd
);
  import stq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECODE    = 7'b0000010,
    S_REMOVE    = 7'b0000100,
    S_SEARCH    = 7'b0001000,
    S_REPLY     = 7'b0010000,
    S_TICK_CHK  = 7'b0100000,
    S_TICK_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   reply_status, reply_status_next;
  logic   due;
  logic   more;

  assign due  = !stat.empty && !stat.time_lt_wake;
  assign more = due && !stat.pop_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      reply_status <= 1'b0;
    end else begin
      state        <= state_next;
      reply_status <= reply_status_next;
    end
  end

  always_comb begin
    state_next        = state;
    reply_status_next = reply_status;
    cmd               = '0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_fire) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        reply_status_next = 1'b0;
        if (stat.op == OP_ARM) begin
          state_next = stat.id_armed ? S_REMOVE : S_SEARCH;
        end else if (stat.op == OP_DISARM) begin
          state_next        = stat.id_armed ? S_REMOVE : S_REPLY;
          reply_status_next = !stat.id_armed;
        end else if (stat.op == OP_TICK) begin
          state_next = S_TICK_CHK;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_REMOVE: begin
        if (stat.slot_match) begin
          cmd.remove  = 1'b1;
          cmd.pos_clr = 1'b1;
          state_next  = (stat.op == OP_ARM) ? S_SEARCH : S_REPLY;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_SEARCH: begin
        if (stat.at_end || !stat.wake_lt_time) begin
          cmd.insert = 1'b1;
          state_next = S_REPLY;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_REPLY: begin
        cmd.use_head = 1'b1;
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = reply_status;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_TICK_CHK: begin
        cmd.use_head = 1'b1;
        if (due) begin
          cmd.pop    = 1'b1;
          state_next = S_TICK_EMIT;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_TICK_EMIT: begin
        cmd.use_head = 1'b1;
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_fired = 1'b1;
          cmd.out_last  = !more;
          state_next    = more ? S_TICK_CHK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sorted_timer_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Sixteen timers kept in a list sorted by wake time, served by arm, disarm
// and tick requests.
// ----------------------------------------------------------------------------
// Arm walks the list to remove the old entry when the timer was armed, then walks
//   to its new position and inserts; disarm walks to the entry and removes it.
// Tick pops due timers from the head, one result each, or replies when none is due.
// One request at a time; the list walk goes one position per clock. The next request
//   is taken the cycle after its last result is loaded, even while that result waits.
// Reset (rst, synchronous) empties the queue and disarms every slot.
`default_nettype none

module sorted_timer_queue_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  stq_in_if.sink     in_req,
  stq_out_if.source  out_res
);
  import stq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each request; it never touches the list
  // directly, only through the command bundle.
  stq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // The datapath holds the sorted slot list, wake times, armed flags and the
  // result register. Every 4-bit timer id names a valid slot.
  stq_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

@@ rtl/stq_checker.sv @@
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on the timer queue result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_status,
  input wire logic               out_fired,
  input wire logic               out_new_earliest,
  input wire logic signed [63:0] out_fired_wake_time,
  input wire logic signed [63:0] out_head_wake_time
);

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An expiry result is never an error and never flags a new head.
  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fired |-> !out_status && !out_new_earliest)
    else $error("expiry result with status or new_earliest set");

  // The list is sorted, so what remains never wakes before what just fired.
  a_fired_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fired |-> out_fired_wake_time <= out_head_wake_time)
    else $error("remaining head earlier than expired timer");

endmodule

bind sorted_timer_queue_unit stq_checker u_stq_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_res.valid),
  .out_ready           (out_res.ready),
  .out_status          (out_res.status),
  .out_fired           (out_res.fired),
  .out_new_earliest    (out_res.new_earliest),
  .out_fired_wake_time (out_res.fired_wake_time),
  .out_head_wake_time  (out_res.head_wake_time)
);

`default_nettype wire
